>>> sv/stack_machine_execute_unit_assert.svh
// ----------------------------------------------------------------------------
// Stack machine execute unit assertion macros
// Shared concurrent assertion forms, clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMEU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMEU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/smeu_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Sizes, opcode and exception codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package smeu_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W = 64;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int HALF_W = DATA_W / 2;
	localparam int STEP_W = $clog2(DATA_W);
	localparam int MUL_LAST = 2;
	localparam int DIV_LAST = DATA_W - 1;

	typedef enum logic [4:0] {
		OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3,
		OP_DIV = 5'd4, OP_MOD = 5'd5, OP_SNE = 5'd6, OP_RSH = 5'd7,
		OP_LSH = 5'd8, OP_OR = 5'd9, OP_AND = 5'd10, OP_XOR = 5'd11,
		OP_EQ = 5'd12, OP_ISZERO = 5'd13, OP_LT = 5'd14, OP_LE = 5'd15,
		OP_GT = 5'd16, OP_GE = 5'd17, OP_DROP = 5'd18, OP_PULL = 5'd19,
		OP_DUP = 5'd20, OP_FSWAP = 5'd21, OP_SWAP = 5'd22, OP_JMP = 5'd23,
		OP_JMPI = 5'd24, OP_CALL = 5'd25, OP_HLT = 5'd26, OP_STI = 5'd27,
		OP_CLI = 5'd28
	} op_t;

	typedef enum logic [2:0] {
		EXC_NONE = 3'd0,
		EXC_UNDERFLOW = 3'd1,
		EXC_DIV_ZERO = 3'd2,
		EXC_BAD_SIZE = 3'd3,
		EXC_BAD_OFFSET = 3'd4,
		EXC_OVERFLOW = 3'd5
	} exc_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD1, S_RD2, S_EXEC, S_MD, S_WR1, S_WR2
	} state_t;

	typedef struct packed {
		logic load;
		logic lat_b;
		logic lat_c;
		logic md_start;
		logic wr_first;
		logic wr_second;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic md_need;
		logic md_done;
	} sts_t;

endpackage

>>> sv/smeu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smeu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/smeu_muldiv.sv
// ----------------------------------------------------------------------------
// Stack machine multiply and divide unit
// Multiplies over three 32x32 partial products, or divides signed values
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module smeu_muldiv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        is_div,
	input  logic                        want_rem,
	input  logic [smeu_pkg::DATA_W-1:0] b,
	input  logic [smeu_pkg::DATA_W-1:0] a,
	output logic                        done,
	output logic [smeu_pkg::DATA_W-1:0] result
);

	localparam int W = smeu_pkg::DATA_W;
	localparam int H = smeu_pkg::HALF_W;

	logic                        busy_q;
	logic                        done_q;
	logic                        div_q;
	logic                        rem_sel_q;
	logic                        neg_quo_q;
	logic                        neg_rem_q;
	logic [smeu_pkg::STEP_W-1:0] step_q;
	logic [W-1:0]                x_q;
	logic [W-1:0]                y_q;
	logic [W-1:0]                acc_q;
	logic [W-1:0]                quo_q;
	logic [W-1:0]                rem_q;

	logic [H-1:0] pa;
	logic [H-1:0] pb;
	logic [W-1:0] prod;
	logic [W:0]   rem_sh;
	logic [W:0]   diff;
	logic         last;

	// Partial product operand selection for the shared multiplier.
	always_comb begin
		case (step_q)
			smeu_pkg::STEP_W'(0): begin
				pa = x_q[H-1:0];
				pb = y_q[H-1:0];
			end
			smeu_pkg::STEP_W'(1): begin
				pa = x_q[H-1:0];
				pb = y_q[W-1:H];
			end
			default: begin
				pa = x_q[W-1:H];
				pb = y_q[H-1:0];
			end
		endcase
		prod = W'(pa) * W'(pb);
	end

	// One restoring division step.
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff = rem_sh - {1'b0, y_q};
	assign last = div_q ? (step_q == smeu_pkg::STEP_W'(smeu_pkg::DIV_LAST))
		: (step_q == smeu_pkg::STEP_W'(smeu_pkg::MUL_LAST));

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + smeu_pkg::STEP_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and working registers.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			rem_sel_q <= want_rem;
			neg_quo_q <= b[W-1] ^ a[W-1];
			neg_rem_q <= b[W-1];
			if (is_div) begin
				x_q <= b;
				y_q <= a[W-1] ? (W'(0) - a) : a;
				quo_q <= b[W-1] ? (W'(0) - b) : b;
			end else begin
				x_q <= b;
				y_q <= a;
				quo_q <= '0;
			end
			rem_q <= '0;
			acc_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end else if (step_q == '0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[H-1:0], H'(0)};
			end
		end
	end

	// Result with the signs applied.
	always_comb begin
		if (!div_q) begin
			result = acc_q;
		end else if (rem_sel_q) begin
			result = neg_rem_q ? (W'(0) - rem_q) : rem_q;
		end else begin
			result = neg_quo_q ? (W'(0) - quo_q) : quo_q;
		end
	end

	assign done = done_q;

endmodule

>>> sv/smeu_datapath.sv
// ----------------------------------------------------------------------------
// Stack machine datapath
// Operand stack memory, top of stack, depth, pc and flags, the operation
// decode and the result register.
// ----------------------------------------------------------------------------
module smeu_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smeu_pkg::cmd_t              cmd,
	output smeu_pkg::sts_t              sts,
	input  logic [4:0]                  operation,
	input  logic signed [63:0]          immediate,
	output logic [2:0]                  exception,
	output logic signed [63:0]          top_value,
	output logic [6:0]                  stack_depth,
	output logic [63:0]                 next_pc,
	output logic                        jumped,
	output logic                        halted,
	output logic                        interrupts_off
);

	localparam int W = smeu_pkg::DATA_W;
	localparam int CW = smeu_pkg::CNT_W;
	localparam int AW = smeu_pkg::ADDR_W;

	// Item and machine state.
	smeu_pkg::op_t op_q;
	logic [W-1:0]  imm_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  c_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  top_q;
	logic [W-1:0]  pc_q;
	logic          halt_q;
	logic          ie_q;

	// Memory ports.
	logic [AW-1:0] raddr;
	logic [W-1:0]  rdata;
	logic          we;
	logic [AW-1:0] waddr;
	logic [W-1:0]  wdata;

	// Decode results.
	logic [W-1:0]  a;
	logic [W-1:0]  n_ext;
	logic [CW-1:0] a_lo;
	logic          has1;
	logic          has2;
	logic          full;
	logic          pull_ok;
	logic          fswap_ok;
	logic [AW-1:0] addr1;
	logic [AW-1:0] addr3;
	logic [AW-1:0] addr2;
	logic [5:0]    sx_sh;
	logic [W-1:0]  sx;
	logic [W-1:0]  md_res;
	logic [W-1:0]  alu;
	logic          md_need;
	logic          md_done;

	smeu_pkg::exc_t o_exc;
	logic [CW-1:0]  o_cnt;
	logic [W-1:0]   o_top;
	logic           w1_en;
	logic [AW-1:0]  w1_addr;
	logic [W-1:0]   w1_data;
	logic           w2_en;
	logic [AW-1:0]  w2_addr;
	logic [W-1:0]   w2_data;
	logic [W-1:0]   o_pc;
	logic           o_jmp;
	logic           o_halt;
	logic           o_ie;

	// Output registers.
	logic [2:0]    exc_out_q;
	logic [W-1:0]  top_out_q;
	logic [CW-1:0] cnt_out_q;
	logic [W-1:0]  pc_out_q;
	logic          jmp_out_q;

	assign a = top_q;
	assign n_ext = W'(cnt_q);
	assign a_lo = a[CW-1:0];
	assign has1 = cnt_q != '0;
	assign has2 = cnt_q >= CW'(2);
	assign full = cnt_q >= CW'(smeu_pkg::STACK_DEPTH);
	assign pull_ok = !a[W-1] && (a < n_ext - W'(1));
	assign fswap_ok = !a[W-1] && (a < n_ext - W'(2));
	assign addr1 = AW'(cnt_q - CW'(2));
	assign addr3 = AW'(cnt_q - CW'(3));

	// Second read: the entry under an offset, else the third entry.
	always_comb begin
		case (op_q)
			smeu_pkg::OP_PULL: addr2 = pull_ok ? AW'(cnt_q - CW'(2) - a_lo) : addr3;
			smeu_pkg::OP_FSWAP: addr2 = fswap_ok ? AW'(cnt_q - CW'(3) - a_lo) : addr3;
			default: addr2 = addr3;
		endcase
	end

	assign raddr = cmd.lat_b ? addr2 : addr1;

	smeu_ram #(
		.WIDTH(W),
		.DEPTH(smeu_pkg::STACK_DEPTH)
	) u_stack (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	smeu_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.md_start),
		.is_div(op_q != smeu_pkg::OP_MUL),
		.want_rem(op_q == smeu_pkg::OP_MOD),
		.b(b_q),
		.a(a),
		.done(md_done),
		.result(md_res)
	);

	assign md_need = has2 && ((op_q == smeu_pkg::OP_MUL)
		|| (((op_q == smeu_pkg::OP_DIV) || (op_q == smeu_pkg::OP_MOD)) && (a != '0)));

	// Status toward the controller.
	assign sts = '{md_need: md_need, md_done: md_done};

	// Sign extension from the low bytes of the value below.
	assign sx_sh = 6'(7'd64 - {a[3:0], 3'b000});
	assign sx = W'($signed(b_q << sx_sh) >>> sx_sh);

	// Binary operations on the value below (b) and the top (a).
	always_comb begin
		case (op_q)
			smeu_pkg::OP_ADD: alu = b_q + a;
			smeu_pkg::OP_SUB: alu = b_q - a;
			smeu_pkg::OP_RSH: alu = W'($signed(b_q) >>> a[5:0]);
			smeu_pkg::OP_LSH: alu = b_q << a[5:0];
			smeu_pkg::OP_OR: alu = b_q | a;
			smeu_pkg::OP_AND: alu = b_q & a;
			smeu_pkg::OP_XOR: alu = b_q ^ a;
			smeu_pkg::OP_EQ: alu = W'(b_q == a);
			smeu_pkg::OP_LT: alu = W'($signed(b_q) < $signed(a));
			smeu_pkg::OP_LE: alu = W'($signed(b_q) <= $signed(a));
			smeu_pkg::OP_GT: alu = W'($signed(b_q) > $signed(a));
			smeu_pkg::OP_GE: alu = W'($signed(b_q) >= $signed(a));
			default: alu = md_res;
		endcase
	end

	// Outcome of the operation: exception, new stack, writes and pc.
	always_comb begin
		o_exc = smeu_pkg::EXC_NONE;
		o_cnt = cnt_q;
		o_top = top_q;
		w1_en = 1'b0;
		w1_addr = AW'(cnt_q);
		w1_data = a;
		w2_en = 1'b0;
		w2_addr = AW'(cnt_q - CW'(1));
		w2_data = c_q;
		o_pc = pc_q + W'(1);
		o_jmp = 1'b0;
		o_halt = halt_q;
		o_ie = ie_q;
		if (halt_q) begin
			o_pc = pc_q;
		end else begin
			case (op_q)
				smeu_pkg::OP_PUSH: begin
					if (full) begin
						o_exc = smeu_pkg::EXC_OVERFLOW;
					end else begin
						o_cnt = cnt_q + CW'(1);
						o_top = imm_q;
						w1_en = 1'b1;
						w1_data = imm_q;
					end
				end
				smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
				smeu_pkg::OP_MOD, smeu_pkg::OP_RSH, smeu_pkg::OP_LSH, smeu_pkg::OP_OR,
				smeu_pkg::OP_AND, smeu_pkg::OP_XOR, smeu_pkg::OP_EQ, smeu_pkg::OP_LT,
				smeu_pkg::OP_LE, smeu_pkg::OP_GT, smeu_pkg::OP_GE: begin
					if (!has1) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
					end else if (((op_q == smeu_pkg::OP_DIV) || (op_q == smeu_pkg::OP_MOD))
						&& (a == '0)) begin
						o_exc = smeu_pkg::EXC_DIV_ZERO;
						o_cnt = cnt_q - CW'(1);
						o_top = b_q;
					end else if (!has2) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
						o_cnt = '0;
					end else begin
						o_cnt = cnt_q - CW'(1);
						o_top = alu;
						w1_en = 1'b1;
						w1_addr = addr1;
						w1_data = alu;
					end
				end
				smeu_pkg::OP_SNE: begin
					if (!has2) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
						o_cnt = '0;
					end else if ((a == '0) || (a > W'(8))) begin
						o_exc = smeu_pkg::EXC_BAD_SIZE;
						o_cnt = cnt_q - CW'(2);
						o_top = c_q;
					end else begin
						o_cnt = cnt_q - CW'(1);
						o_top = sx;
						w1_en = 1'b1;
						w1_addr = addr1;
						w1_data = sx;
					end
				end
				smeu_pkg::OP_ISZERO: begin
					if (!has1) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
					end else begin
						o_top = W'(a == '0);
						w1_en = 1'b1;
						w1_addr = AW'(cnt_q - CW'(1));
						w1_data = W'(a == '0);
					end
				end
				smeu_pkg::OP_DROP: begin
					if (!has1) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
					end else begin
						o_cnt = cnt_q - CW'(1);
						o_top = b_q;
					end
				end
				smeu_pkg::OP_PULL: begin
					if (!has1) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
					end else if (a[W-1]) begin
						o_exc = smeu_pkg::EXC_BAD_OFFSET;
						o_cnt = cnt_q - CW'(1);
						o_top = b_q;
					end else if (!pull_ok) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
						o_cnt = cnt_q - CW'(1);
						o_top = b_q;
					end else begin
						o_top = c_q;
						w1_en = 1'b1;
						w1_addr = AW'(cnt_q - CW'(1));
						w1_data = c_q;
					end
				end
				smeu_pkg::OP_DUP: begin
					if (!has1) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
					end else if (full) begin
						o_exc = smeu_pkg::EXC_OVERFLOW;
					end else begin
						o_cnt = cnt_q + CW'(1);
						w1_en = 1'b1;
					end
				end
				smeu_pkg::OP_FSWAP: begin
					if (!has2) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
						o_cnt = '0;
					end else if (a[W-1]) begin
						o_exc = smeu_pkg::EXC_BAD_OFFSET;
						o_cnt = cnt_q - CW'(2);
						o_top = c_q;
					end else if (!fswap_ok) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
						o_cnt = cnt_q - CW'(2);
						o_top = c_q;
					end else begin
						o_cnt = cnt_q - CW'(1);
						o_top = c_q;
						w1_en = 1'b1;
						w1_addr = addr2;
						w1_data = b_q;
						w2_en = 1'b1;
						w2_addr = addr1;
						w2_data = c_q;
					end
				end
				smeu_pkg::OP_SWAP: begin
					if (!has2) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
						o_cnt = '0;
					end else begin
						o_top = b_q;
						w1_en = 1'b1;
						w1_addr = addr1;
						w1_data = a;
						w2_en = 1'b1;
						w2_data = b_q;
					end
				end
				smeu_pkg::OP_JMP: begin
					if (!has1) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
					end else begin
						o_cnt = cnt_q - CW'(1);
						o_top = b_q;
						o_pc = a;
						o_jmp = 1'b1;
					end
				end
				smeu_pkg::OP_JMPI: begin
					if (!has2) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
						o_cnt = '0;
					end else begin
						o_cnt = cnt_q - CW'(2);
						o_top = c_q;
						if (b_q != '0) begin
							o_pc = a;
							o_jmp = 1'b1;
						end
					end
				end
				smeu_pkg::OP_CALL: begin
					if (!has1) begin
						o_exc = smeu_pkg::EXC_UNDERFLOW;
					end else begin
						o_top = pc_q + W'(1);
						w1_en = 1'b1;
						w1_addr = AW'(cnt_q - CW'(1));
						w1_data = pc_q + W'(1);
						o_pc = a;
						o_jmp = 1'b1;
					end
				end
				smeu_pkg::OP_HLT: o_halt = 1'b1;
				smeu_pkg::OP_STI: o_ie = 1'b0;
				smeu_pkg::OP_CLI: o_ie = 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Memory write port: first write, then second write.
	assign we = (cmd.wr_first && w1_en) || (cmd.wr_second && w2_en);
	assign waddr = cmd.wr_second ? w2_addr : w1_addr;
	assign wdata = cmd.wr_second ? w2_data : w1_data;

	// Item capture and operand reads.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= smeu_pkg::op_t'(operation);
			imm_q <= W'(immediate);
		end
		if (cmd.lat_b) begin
			b_q <= rdata;
		end
		if (cmd.lat_c) begin
			c_q <= rdata;
		end
	end

	// Machine state, updated when the transaction commits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pc_q <= '0;
			halt_q <= 1'b0;
			ie_q <= 1'b0;
		end else if (cmd.commit) begin
			cnt_q <= o_cnt;
			pc_q <= o_pc;
			halt_q <= o_halt;
			ie_q <= o_ie;
		end
	end

	// Top of stack and the result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			top_q <= o_top;
			exc_out_q <= o_exc;
			top_out_q <= (o_cnt != '0) ? o_top : '0;
			cnt_out_q <= o_cnt;
			pc_out_q <= o_pc;
			jmp_out_q <= o_jmp;
		end
	end

	assign exception = exc_out_q;
	assign top_value = top_out_q;
	assign stack_depth = 7'(cnt_out_q);
	assign next_pc = pc_out_q;
	assign jumped = jmp_out_q;
	assign halted = halt_q;
	assign interrupts_off = ie_q;

endmodule

>>> sv/smeu_ctrl.sv
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences operand reads, the multiply and divide unit, write-back and the
// result handshake.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_unit_assert.svh"

module smeu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  smeu_pkg::sts_t sts,
	output smeu_pkg::cmd_t cmd
);

	smeu_pkg::state_t state_q;
	smeu_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smeu_pkg::S_IDLE: if (in_valid) state_d = smeu_pkg::S_RD1;
			smeu_pkg::S_RD1: state_d = smeu_pkg::S_RD2;
			smeu_pkg::S_RD2: state_d = smeu_pkg::S_EXEC;
			smeu_pkg::S_EXEC: state_d = sts.md_need ? smeu_pkg::S_MD : smeu_pkg::S_WR1;
			smeu_pkg::S_MD: if (sts.md_done) state_d = smeu_pkg::S_WR1;
			smeu_pkg::S_WR1: state_d = smeu_pkg::S_WR2;
			smeu_pkg::S_WR2: if (out_free) state_d = smeu_pkg::S_IDLE;
			default: state_d = smeu_pkg::S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			smeu_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			smeu_pkg::S_RD1: cmd.lat_b = 1'b1;
			smeu_pkg::S_RD2: cmd.lat_c = 1'b1;
			smeu_pkg::S_EXEC: cmd.md_start = sts.md_need;
			smeu_pkg::S_MD: begin
			end
			smeu_pkg::S_WR1: cmd.wr_first = 1'b1;
			smeu_pkg::S_WR2: begin
				cmd.wr_second = 1'b1;
				cmd.commit = out_free;
			end
			default: begin
			end
		endcase
	end

	// State register and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smeu_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`SMEU_ASSERT_SAME(a_commit_free, cmd.commit, !out_valid_q || out_ready, "commit over unread result")
	`SMEU_ASSERT_NEXT(a_accept_reads, in_valid && in_ready, state_q == smeu_pkg::S_RD1, "accept without read")
	`SMEU_ASSERT_NEXT(a_start_waits, cmd.md_start, state_q == smeu_pkg::S_MD, "divider start lost")
	`SMEU_ASSERT_SAME(a_done_in_md, sts.md_done, state_q == smeu_pkg::S_MD, "unit done out of sequence")

endmodule

>>> sv/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one 64-bit stack machine opcode per input transaction.
//
//   Channel   Direction   Signals
//   input     in          in_valid, in_ready, operation, immediate
//   output    out         out_valid, out_ready, exception, top_value,
//                         stack_depth, next_pc, jumped, halted, interrupts_off
//
// A transaction passes RD1, RD2, EXEC, WR1 and WR2 after acceptance; its result
// is valid once it commits in WR2, and the next one is accepted back in IDLE.
// With two operands, mul, and div or mod with a nonzero divisor, also pass S_MD
// in the multiply and divide unit, the divide bit-serially. The single read port
// of the stack memory sets separate operand reads in RD1 and RD2. Reset needs no
// clearing pass; the stack is empty after reset. A new transaction is accepted
// while a result waits; it stalls at write-back until the result register is taken.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         operation,
	input  logic signed [63:0] immediate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         exception,
	output logic signed [63:0] top_value,
	output logic [6:0]         stack_depth,
	output logic [63:0]        next_pc,
	output logic               jumped,
	output logic               halted,
	output logic               interrupts_off
);

	smeu_pkg::cmd_t cmd;
	smeu_pkg::sts_t sts;

	smeu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	smeu_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.operation(operation),
		.immediate(immediate),
		.exception(exception),
		.top_value(top_value),
		.stack_depth(stack_depth),
		.next_pc(next_pc),
		.jumped(jumped),
		.halted(halted),
		.interrupts_off(interrupts_off)
	);

endmodule
